@@ rtl/bllc_pkg.sv @@
// Shared types and constants for the bin level lock alarm block.
// No dependencies; the divider, datapath, controller and top import this package.
package bllc_pkg;

  localparam int NUM_ECHOES = 5;
  localparam int ECW        = $clog2(NUM_ECHOES);

  localparam int ECHO_W = 15;
  localparam int DIST_W = 10;
  localparam int PCT_W  = 7;
  localparam int EV_W   = 3;
  localparam int CNT_W  = 4;
  localparam int RUN_W  = 8;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 9;

  // cm = floor(t*34/2000) = (t * CM_MULT) >> CM_SHIFT, exact for t < 2^15
  localparam int           CM_SHIFT  = 29;
  localparam int           CM_PROD_W = ECHO_W + 24;
  localparam logic [23:0]  CM_MULT   = 24'd9126807;
  localparam logic [DIST_W-1:0] NO_ECHO_CM = 10'd999;
  localparam logic [DIST_W-1:0] DIST_RESET = 10'd30;
  localparam logic [PCT_W-1:0]  PCT_MAX    = 7'd100;

  // fill percent divider
  localparam int DVD_W = 16;
  localparam int DSR_W = 9;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  // modes
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_TIME   = 2'd1;
  localparam logic [1:0] MODE_CARD   = 2'd2;

  // events
  localparam logic [EV_W-1:0] EV_NONE     = 3'd0;
  localparam logic [EV_W-1:0] EV_FULL     = 3'd1;
  localparam logic [EV_W-1:0] EV_EMPTIED  = 3'd2;
  localparam logic [EV_W-1:0] EV_REMINDER = 3'd3;
  localparam logic [EV_W-1:0] EV_CARD     = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_FULL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USABLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAXREM   = 3'd6;

  typedef struct packed {
    logic [CFG_W-1:0]  full_distance_cm;
    logic [CFG_W-1:0]  empty_distance_cm;
    logic [CFG_W-1:0]  depth_cm;
    logic [CFG_W-1:0]  span_cm;
    logic [RUN_W-1:0]  confirm_count;
    logic [TIME_W-1:0] reminder_interval_ms;
    logic [CNT_W-1:0]  max_reminders;
  } cfg_t;

  typedef struct packed {
    logic           in_ready;
    logic           mul_en;
    logic           sto_en;
    logic           sort_en;
    logic           upd_en;
    logic           div_start;
    logic           out_load;
    logic [ECW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic accept;
    logic absent;
    logic sample;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

@@ rtl/bllc_in_if.sv @@
// Input channel of the bin level lock alarm: valid/ready plus the item fields.
// Uses no package.
interface bllc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        bin;
  logic [31:0] now_ms;
  logic [14:0] echo_0;
  logic [14:0] echo_1;
  logic [14:0] echo_2;
  logic [14:0] echo_3;
  logic [14:0] echo_4;

  modport source (output valid, mode, bin, now_ms, echo_0, echo_1, echo_2, echo_3, echo_4,
                  input ready);
  modport sink   (input valid, mode, bin, now_ms, echo_0, echo_1, echo_2, echo_3, echo_4,
                  output ready);
endinterface

@@ rtl/bllc_out_if.sv @@
// Result channel of the bin level lock alarm: valid/ready plus the result fields.
// Uses no package.
interface bllc_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] distance_cm;
  logic [6:0] level_pct;
  logic       is_locked;
  logic [2:0] event_res;
  logic [3:0] alert_number;

  modport source (output valid, distance_cm, level_pct, is_locked, event_res, alert_number,
                  input ready);
  modport sink   (input valid, distance_cm, level_pct, is_locked, event_res, alert_number,
                  output ready);
endinterface

@@ rtl/bllc_div.sv @@
// Radix-2 restoring divider for the fill percent, one quotient bit per cycle.
// Depends on bllc_pkg.
module bllc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bllc_pkg::DVD_W-1:0] dividend,
  input  logic [bllc_pkg::DSR_W-1:0] divisor,
  output logic                       busy,
  output logic [bllc_pkg::DVD_W-1:0] quotient
);
  import bllc_pkg::*;

  logic [DSR_W-1:0]     rem;
  logic [DVD_W-1:0]     quo;
  logic [DSR_W-1:0]     dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DSR_W:0]       rem_sh;
  logic [DSR_W:0]       rem_diff;
  logic                 ge;

  assign rem_sh   = {rem, quo[DVD_W-1]};
  assign ge       = rem_sh >= {1'b0, dsr};
  assign rem_diff = rem_sh - {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DVD_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? rem_diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

endmodule

@@ rtl/bllc_dp.sv @@
// Datapath: input latch, echo conversion, sort array, per-bin state, fill
// percent and result register. Depends on bllc_pkg, the channel interfaces, bllc_div.
module bllc_dp #(
  parameter int NUM_BINS = 2
) (
  input  logic              clk,
  input  logic              rst,
  bllc_in_if.sink           req,
  bllc_out_if.source        rsp,
  input  bllc_pkg::cfg_t    cfg,
  input  bllc_pkg::cmd_t    cmd,
  output bllc_pkg::status_t status
);
  import bllc_pkg::*;

  localparam int BIW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  // latched item
  logic [1:0]        mode_r;
  logic              bin_r;
  logic [TIME_W-1:0] now_r;
  logic [ECHO_W-1:0] echo [NUM_ECHOES];

  // conversion and sort
  logic [CM_PROD_W-1:0] prod;
  logic                 prod_zero;
  logic [DIST_W-1:0]    val [NUM_ECHOES];
  logic [DIST_W-1:0]    val_next [NUM_ECHOES];

  // per-bin state
  logic              locked   [NUM_BINS];
  logic [RUN_W-1:0]  full_run [NUM_BINS];
  logic [RUN_W-1:0]  empty_run[NUM_BINS];
  logic [CNT_W-1:0]  alerts   [NUM_BINS];
  logic [TIME_W-1:0] last_time[NUM_BINS];
  logic [DIST_W-1:0] last_dist[NUM_BINS];

  // updated values of the addressed bin
  logic              lk_next;
  logic [RUN_W-1:0]  fr_next, er_next;
  logic [CNT_W-1:0]  al_next;
  logic [TIME_W-1:0] lt_next;
  logic [DIST_W-1:0] ld_next;
  logic [EV_W-1:0]   ev_next;

  // result fields before the output register
  logic [DIST_W-1:0] res_dist;
  logic              res_lock;
  logic [EV_W-1:0]   res_ev;
  logic [CNT_W-1:0]  res_alerts;

  logic              out_valid;
  logic [BIW-1:0]    bidx;
  logic              accept;
  logic              absent;
  logic              div_busy;

  assign bidx   = BIW'(bin_r);
  assign absent = {3'b000, bin_r} >= 4'(NUM_BINS);
  assign accept = req.valid && req.ready;
  assign req.ready = cmd.in_ready;

  assign status.accept   = accept;
  assign status.absent   = absent;
  assign status.sample   = (mode_r == MODE_SAMPLE);
  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= req.mode;
      bin_r   <= req.bin;
      now_r   <= req.now_ms;
      echo[0] <= req.echo_0;
      echo[1] <= req.echo_1;
      echo[2] <= req.echo_2;
      echo[3] <= req.echo_3;
      echo[4] <= req.echo_4;
    end
  end

  // echo to cm: multiply in one step, shift and store in the next
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod      <= CM_PROD_W'(echo[cmd.idx]) * CM_PROD_W'(CM_MULT);
      prod_zero <= (echo[cmd.idx] == '0);
    end
  end

  // one odd-even transposition pass per cycle
  always_comb begin
    for (int i = 0; i < NUM_ECHOES; i++) begin
      val_next[i] = val[i];
    end
    for (int i = 0; i < NUM_ECHOES - 1; i++) begin
      if (i[0] == cmd.idx[0] && val[i] > val[i+1]) begin
        val_next[i]   = val[i+1];
        val_next[i+1] = val[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sto_en) begin
      val[cmd.idx] <= prod_zero ? NO_ECHO_CM : prod[CM_SHIFT +: DIST_W];
    end else if (cmd.sort_en) begin
      for (int i = 0; i < NUM_ECHOES; i++) begin
        val[i] <= val_next[i];
      end
    end
  end

  // state update of the addressed bin
  always_comb begin
    logic [RUN_W-1:0]  need;
    logic [DIST_W-1:0] d;
    need    = (cfg.confirm_count == '0) ? RUN_W'(1) : cfg.confirm_count;
    d       = val[NUM_ECHOES/2];
    lk_next = locked[bidx];
    fr_next = full_run[bidx];
    er_next = empty_run[bidx];
    al_next = alerts[bidx];
    lt_next = last_time[bidx];
    ld_next = last_dist[bidx];
    ev_next = EV_NONE;
    unique case (mode_r)
      MODE_SAMPLE: begin
        ld_next = d;
        if (!locked[bidx]) begin
          if (d <= {1'b0, cfg.full_distance_cm}) begin
            fr_next = (fr_next == '1) ? fr_next : fr_next + 1'b1;
            er_next = '0;
          end else begin
            fr_next = '0;
          end
          if (fr_next >= need) begin
            fr_next = '0;
            lk_next = 1'b1;
            al_next = CNT_W'(1);
            lt_next = now_r;
            ev_next = EV_FULL;
          end
        end else begin
          if (d >= {1'b0, cfg.empty_distance_cm}) begin
            er_next = (er_next == '1) ? er_next : er_next + 1'b1;
            fr_next = '0;
          end else begin
            er_next = '0;
          end
          if (er_next >= need) begin
            er_next = '0;
            lk_next = 1'b0;
            al_next = '0;
            ev_next = EV_EMPTIED;
          end
        end
      end
      MODE_TIME: begin
        if (locked[bidx] && alerts[bidx] < cfg.max_reminders &&
            (now_r - last_time[bidx]) >= cfg.reminder_interval_ms) begin
          al_next = alerts[bidx] + 1'b1;
          lt_next = now_r;
          ev_next = EV_REMINDER;
        end
      end
      MODE_CARD: begin
        lk_next = 1'b0;
        al_next = '0;
        ev_next = EV_CARD;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BINS; b++) begin
        locked[b]    <= 1'b0;
        full_run[b]  <= '0;
        empty_run[b] <= '0;
        alerts[b]    <= '0;
        last_time[b] <= '0;
        last_dist[b] <= DIST_RESET;
      end
    end else if (cmd.upd_en && !absent) begin
      locked[bidx]    <= lk_next;
      full_run[bidx]  <= fr_next;
      empty_run[bidx] <= er_next;
      alerts[bidx]    <= al_next;
      last_time[bidx] <= lt_next;
      last_dist[bidx] <= ld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_en) begin
      res_dist   <= ld_next;
      res_lock   <= lk_next;
      res_ev     <= ev_next;
      res_alerts <= al_next;
    end
  end

  // fill percent: clamp, subtract, scale, divide
  logic [DIST_W-1:0] dc;
  logic [CFG_W-1:0]  filled;
  logic [DVD_W-1:0]  dividend;
  logic [DSR_W-1:0]  divisor;
  logic [DVD_W-1:0]  quotient;
  logic [PCT_W-1:0]  pct;

  always_comb begin
    if (res_dist < {1'b0, cfg.full_distance_cm}) begin
      dc = {1'b0, cfg.full_distance_cm};
    end else if (res_dist > {1'b0, cfg.depth_cm}) begin
      dc = {1'b0, cfg.depth_cm};
    end else begin
      dc = res_dist;
    end
    filled   = (dc < {1'b0, cfg.depth_cm}) ? cfg.depth_cm - dc[CFG_W-1:0] : '0;
    dividend = DVD_W'(filled) * DVD_W'(100);
    divisor  = (cfg.span_cm == '0) ? DSR_W'(1) : cfg.span_cm;
    pct      = (quotient > DVD_W'(PCT_MAX)) ? PCT_MAX : quotient[PCT_W-1:0];
  end

  bllc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.distance_cm  <= absent ? '0 : res_dist;
      rsp.level_pct    <= absent ? '0 : pct;
      rsp.is_locked    <= absent ? 1'b0 : res_lock;
      rsp.event_res    <= absent ? EV_NONE : res_ev;
      rsp.alert_number <= absent ? '0 : res_alerts;
    end
  end

  assign rsp.valid = out_valid;

endmodule

@@ rtl/bllc_ctrl.sv @@
// Controller state machine: sequences conversion, sort, update, divide and
// result handoff. Depends on bllc_pkg.
module bllc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  bllc_pkg::status_t status,
  output bllc_pkg::cmd_t    cmd
);
  import bllc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_STO  = 4'd3;
  localparam logic [3:0] S_SORT = 4'd4;
  localparam logic [3:0] S_UPD  = 4'd5;
  localparam logic [3:0] S_PREP = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  localparam logic [ECW-1:0] IDX_LAST = ECW'(NUM_ECHOES - 1);

  logic [3:0]     state, state_next;
  logic [ECW-1:0] idx, idx_next;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    cmd.idx    = idx;
    unique case (state)
      S_IDLE: begin
        // no item taken while reset is held
        cmd.in_ready = !rst;
        if (status.accept) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        idx_next = '0;
        priority if (status.absent) begin
          state_next = S_FIN;
        end else if (status.sample) begin
          state_next = S_MUL;
        end else begin
          state_next = S_UPD;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_STO;
      end
      S_STO: begin
        cmd.sto_en = 1'b1;
        if (idx == IDX_LAST) begin
          idx_next   = '0;
          state_next = S_SORT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_MUL;
        end
      end
      S_SORT: begin
        cmd.sort_en = 1'b1;
        if (idx == IDX_LAST) begin
          idx_next   = '0;
          state_next = S_UPD;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_UPD: begin
        cmd.upd_en = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

@@ rtl/bin_level_lock_alarm_top.sv @@
// Top level of the two-bin fill monitor with lock and reminder alerts.
// Holds the configuration registers; depends on bllc_pkg, the interfaces, bllc_ctrl, bllc_dp.
//
//   channel  dir  handshake     item
//   req      in   valid/ready   mode, bin, now_ms, echo_0..echo_4
//   rsp      out  valid/ready   distance_cm, level_pct, is_locked, event_res, alert_number
//   wr_*     in   wr_en only    register index, 32-bit data
//
// Sequence: a sample item runs from accept through dispatch, five echo multiply/store
//   pairs, five sort passes, update, divider start, the divider steps (one quotient
//   bit each), a state that sees it finish and handoff; time and card items skip the
//   pairs and passes. The serial divider and the shared echo multiplier shape this sequence.
// Reset: synchronous, active high; clears the sequencer, the per-bin state and
//   restores register defaults. No item is taken while reset is held.
// Stalls: the next item is taken while a result waits in the output register;
//   only the handoff step waits for rsp.ready.
module bin_level_lock_alarm_top #(
  parameter int NUM_BINS = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  bllc_in_if.sink                         req,
  bllc_out_if.source                      rsp,
  input  logic                            wr_en,
  input  logic [bllc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [bllc_pkg::CFG_DATA_W-1:0] wr_data
);
  import bllc_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // configuration registers; the user must write them only while no item is in flight; not enforced here
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_distance_cm     <= 9'd10;
      cfg.empty_distance_cm    <= 9'd25;
      cfg.depth_cm             <= 9'd30;
      cfg.span_cm              <= 9'd20;
      cfg.confirm_count        <= 8'd3;
      cfg.reminder_interval_ms <= 32'd28800000;
      cfg.max_reminders        <= 4'd3;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FULL:     cfg.full_distance_cm     <= wr_data[CFG_W-1:0];
        REG_EMPTY:    cfg.empty_distance_cm    <= wr_data[CFG_W-1:0];
        REG_DEPTH:    cfg.depth_cm             <= wr_data[CFG_W-1:0];
        REG_USABLE:   cfg.span_cm              <= wr_data[CFG_W-1:0];
        REG_CONFIRM:  cfg.confirm_count        <= wr_data[RUN_W-1:0];
        REG_INTERVAL: cfg.reminder_interval_ms <= wr_data[TIME_W-1:0];
        REG_MAXREM:   cfg.max_reminders        <= wr_data[CNT_W-1:0];
        default: begin
          // index beyond the register list: ignored
        end
      endcase
    end
  end

  bllc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  bllc_dp #(
    .NUM_BINS (NUM_BINS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status)
  );

  // result only loads into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over a waiting result");

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second item accepted while one is in flight");

  // percent never leaves its range
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.level_pct <= PCT_MAX))
    else $error("fill percent above 100");

  // divider runs only between its start and the handoff
  a_div_quiet: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !status.div_busy)
    else $error("divider busy while idle");

endmodule
